// ----- hw/rtl/rgb_image_mean_max_abs_deviation_top_macros.svh -----
// assertion macros for the rgb mean / max deviation block
// used by the checker module; needs i_clk and i_rst_n in scope
`ifndef RGB_IMAGE_MEAN_MAX_ABS_DEVIATION_TOP_MACROS_SVH
`define RGB_IMAGE_MEAN_MAX_ABS_DEVIATION_TOP_MACROS_SVH

// same-cycle implication
`define RGBMAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RGBMAD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rgbmad_pkg.sv -----
// shared widths, register indexes and helpers for the rgb deviation block
// no dependencies
package rgbmad_pkg;

    localparam int PIX_W   = 8;
    localparam int DEV_W   = 10;
    localparam int SUM_W   = 34;
    localparam int CNT_W   = 24;
    localparam int AREA_W  = 25;
    localparam int DIM_W   = 13;
    localparam int FRAC_W  = 8;
    localparam int DVD_W   = SUM_W + FRAC_W;
    localparam int DIV_W   = 26;
    localparam int MEAN_W  = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] DIM_MAX   = 13'd4096;
    localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rgb_image_mean_max_abs_deviation_top.sv -----
// channel   | direction | handshake               | payload
// pixel in  | input     | i_in_valid / o_in_stall | i_orig_*, i_cmp_* (8 bits each)
// result    | output    | o_out_valid / i_out_stall | o_mean_deviation, o_max_deviation
// config    | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// a pixel pair goes through accept, three passes of the shared abs-diff unit, then accumulate
// the last pixel of a frame then starts the divider (42 quotient bits and a done pulse), and
// the result register loads after it, later if the previous result is still held
// i_rst_n is synchronous; it clears the frame state and loads 640 x 480
// o_in_stall is high whenever a transaction is in progress
// depends on rgbmad_pkg and rgbmad_div
module rgb_image_mean_max_abs_deviation_top
    import rgbmad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_orig_red,
    input  logic [PIX_W-1:0]     i_orig_green,
    input  logic [PIX_W-1:0]     i_orig_blue,
    input  logic [PIX_W-1:0]     i_cmp_red,
    input  logic [PIX_W-1:0]     i_cmp_green,
    input  logic [PIX_W-1:0]     i_cmp_blue,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [MEAN_W-1:0]    o_mean_deviation,
    output logic [DEV_W-1:0]     o_max_deviation
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHAN = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [1:0]        r_ch;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [DEV_W-1:0]  r_peak;
    logic [DEV_W-1:0]  r_dev;
    logic [AREA_W-1:0] r_area;
    logic [DEV_W-1:0]  r_peak_out;
    logic              r_out_valid;
    logic [MEAN_W-1:0] r_mean;
    logic [DEV_W-1:0]  r_max;
    t_pix              r_orig [3];
    t_pix              r_cmp  [3];

    logic              w_accept;
    logic              w_out_free;
    t_pix              w_a;
    t_pix              w_b;
    t_pix              w_absdiff;
    logic [SUM_W-1:0]  n_sum;
    logic [DEV_W-1:0]  n_peak;
    logic [AREA_W-1:0] w_taken;
    logic              w_last;
    logic [DIV_W-1:0]  w_divisor;
    logic [2*DIM_W-1:0] w_area_full;
    logic              w_div_start;
    logic              w_div_done;
    logic [MEAN_W-1:0] w_quot;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // shared abs-diff unit, one channel per cycle
    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_a = r_orig[0];
                w_b = r_cmp[0];
            end
            CH_GREEN: begin
                w_a = r_orig[1];
                w_b = r_cmp[1];
            end
            CH_BLUE: begin
                w_a = r_orig[2];
                w_b = r_cmp[2];
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
        w_absdiff = (w_a >= w_b) ? (w_a - w_b) : (w_b - w_a);
    end

    always_comb begin
        w_area_full = clamp_dim(r_width) * clamp_dim(r_height);
        n_sum       = r_sum + SUM_W'(r_dev);
        n_peak      = (r_dev > r_peak) ? r_dev : r_peak;
        w_taken     = {1'b0, r_count} + AREA_W'(1);
        w_last      = (w_taken >= r_area);
        w_divisor   = {1'b0, r_area} + {r_area, 1'b0};
        w_div_start = (r_state == S_ACC) && w_last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CHAN;
            S_CHAN: if (r_ch == CH_BLUE) n_state = S_ACC;
            S_ACC:  n_state = w_last ? S_DIV : S_IDLE;
            S_DIV:  if (w_div_done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= CH_RED;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_count     <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_ch <= CH_RED;
            end else if (r_state == S_CHAN) begin
                r_ch <= r_ch + 2'd1;
            end
            if (r_state == S_ACC) begin
                if (w_last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_peak  <= '0;
                end else begin
                    r_count <= w_taken[CNT_W-1:0];
                    r_sum   <= n_sum;
                    r_peak  <= n_peak;
                end
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_orig[0] <= i_orig_red;
            r_orig[1] <= i_orig_green;
            r_orig[2] <= i_orig_blue;
            r_cmp[0]  <= i_cmp_red;
            r_cmp[1]  <= i_cmp_green;
            r_cmp[2]  <= i_cmp_blue;
            r_dev     <= '0;
        end else if (r_state == S_CHAN) begin
            r_dev  <= r_dev + DEV_W'(w_absdiff);
            r_area <= w_area_full[AREA_W-1:0];
        end
        if (r_state == S_ACC && w_last) begin
            r_peak_out <= n_peak;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_mean <= w_quot;
            r_max  <= r_peak_out;
        end
    end

    rgbmad_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({n_sum, FRAC_W'(0)}),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_mean_deviation = r_mean;
    assign o_max_deviation  = r_max;

endmodule

// ----- hw/rtl/rgbmad_div.sv -----
// restoring divider, one quotient bit per cycle, keeps the low quotient bits
// depends on rgbmad_pkg
module rgbmad_div
    import rgbmad_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [MEAN_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_rem;
    logic [MEAN_W-1:0] r_q;

    logic [DIV_W:0]    w_part;
    logic [DIV_W+1:0]  w_diff;
    logic              w_ge;

    always_comb begin
        w_part = {r_rem, r_dvd[DVD_W-1]};
        w_diff = {1'b0, w_part} - {2'b00, r_div};
        w_ge   = ~w_diff[DIV_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_part[DIV_W-1:0];
            r_q   <= {r_q[MEAN_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/rgbmad_chk.sv -----
// port-level checks for the rgb deviation block, bound to the top level
// depends on rgbmad_pkg and rgb_image_mean_max_abs_deviation_top_macros.svh
`include "rgb_image_mean_max_abs_deviation_top_macros.svh"

module rgbmad_chk
    import rgbmad_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [MEAN_W-1:0]    o_mean_deviation,
    input logic [DEV_W-1:0]     o_max_deviation
);

    logic w_in_acc;
    logic w_out_held;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_held = o_out_valid && i_out_stall;

    // an accepted pixel transaction sets o_in_stall, so the block is busy after it
    `RGBMAD_ASSERT_NXT(a_busy_after_in, w_in_acc, o_in_stall, "idle right after transaction")

    // peak is a sum of three 8-bit differences
    `RGBMAD_ASSERT_NOW(a_max_range, o_out_valid, o_max_deviation <= 10'd765, "max out of range")

    `RGBMAD_ASSERT_NXT(a_out_hold, w_out_held, o_out_valid, "result dropped while stalled")

    `RGBMAD_ASSERT_NXT(a_mean_stable, w_out_held, $stable(o_mean_deviation), "mean changed")

    `RGBMAD_ASSERT_NXT(a_max_stable, w_out_held, $stable(o_max_deviation), "max changed")

endmodule

bind rgb_image_mean_max_abs_deviation_top rgbmad_chk u_rgbmad_chk (.*);
